[sv/eci_pkg.sv]
// ----------------------------------------------------------------------------
// eci_pkg
// Types and constants shared by the event channel interconnect files.
// ----------------------------------------------------------------------------
package eci_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SelW  = 3;
  localparam int unsigned GrpW  = 3;
  localparam int unsigned ChW   = 8;
  localparam int unsigned ReqW  = 2;

  localparam int unsigned SubOnBit = 31;

  typedef enum logic [ReqW-1:0] {
    ReqRead  = 2'd0,
    ReqWrite = 2'd1,
    ReqEvent = 2'd2
  } req_type_e;

  typedef enum logic [SelW-1:0] {
    SelChen    = 3'd0,
    SelChenSet = 3'd1,
    SelChenClr = 3'd2,
    SelGrpMask = 3'd3,
    SelGrpEn   = 3'd4,
    SelGrpDis  = 3'd5,
    SelSubEn   = 3'd6,
    SelSubDis  = 3'd7
  } reg_sel_e;

  typedef struct packed {
    logic           on;
    logic [ChW-1:0] ch;
  } sub_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             event_passed;
    logic [DataW-1:0] channel_enables;
    logic             bad_index;
  } rsp_t;

  function automatic logic [DataW-1:0] sub_word(sub_t s);
    sub_word = {s.on, {(DataW-ChW-1){1'b0}}, s.ch};
  endfunction

endpackage

[sv/eci_req_if.sv]
// ----------------------------------------------------------------------------
// eci_req_if
// Request channel: bus reads, bus writes and published events.
// ----------------------------------------------------------------------------
interface eci_req_if;
  logic                         valid;
  logic                         ready;
  logic [eci_pkg::ReqW-1:0]     req_type;
  logic [eci_pkg::SelW-1:0]     reg_sel;
  logic [eci_pkg::GrpW-1:0]     group_index;
  logic [eci_pkg::DataW-1:0]    write_data;
  logic [eci_pkg::ChW-1:0]      event_channel;

  modport source (
    output valid, req_type, reg_sel, group_index, write_data, event_channel,
    input  ready
  );
  modport sink (
    input  valid, req_type, reg_sel, group_index, write_data, event_channel,
    output ready
  );
endinterface

[sv/eci_rsp_if.sv]
// ----------------------------------------------------------------------------
// eci_rsp_if
// Response channel: one result transaction per request.
// ----------------------------------------------------------------------------
interface eci_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [eci_pkg::DataW-1:0] read_data;
  logic                      event_passed;
  logic [eci_pkg::DataW-1:0] channel_enables;
  logic                      bad_index;

  modport source (
    output valid, read_data, event_passed, channel_enables, bad_index,
    input  ready
  );
  modport sink (
    input  valid, read_data, event_passed, channel_enables, bad_index,
    output ready
  );
endinterface

[sv/event_channel_interconnect_core.sv]
// ----------------------------------------------------------------------------
// event_channel_interconnect_core
// Channel enable mask, group masks and group subscriptions; bus access and
// event gating with group enable/disable firing.
// ----------------------------------------------------------------------------
//   channel  dir  contents
//   req_i    in   req_type, reg_sel, group_index, write_data, event_channel
//   rsp_o    out  read_data, event_passed, channel_enables, bad_index
//
// One transaction per cycle while req_i is ready; state updates at acceptance,
// and the result is registered in the output register or, if that is held, the skid entry.
// A two-entry output (register plus skid) keeps req_i ready while one result
// waits; req_i stalls only when both entries are full.
// Asynchronous active-low reset clears all masks and subscriptions.
// ----------------------------------------------------------------------------
module event_channel_interconnect_core #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned NUM_GROUPS   = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  eci_req_if.sink    req_i,
  eci_rsp_if.source  rsp_o
);

  localparam int unsigned DW = eci_pkg::DataW;
  localparam logic [DW-1:0] ChMask = {DW{1'b1}} >> (DW - NUM_CHANNELS);
  localparam logic [eci_pkg::GrpW:0] GrpLim = (eci_pkg::GrpW+1)'(NUM_GROUPS);
  localparam logic [eci_pkg::ChW:0]  ChLim  = (eci_pkg::ChW+1)'(NUM_CHANNELS);
  localparam int unsigned ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [DW-1:0]     en_q, en_d;
  logic [DW-1:0]     gmask_q [NUM_GROUPS];
  eci_pkg::sub_t     suben_q [NUM_GROUPS];
  eci_pkg::sub_t     subdis_q[NUM_GROUPS];

  eci_pkg::rsp_t     out_q, out_d, skid_q, res;
  logic              out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;

  eci_pkg::req_type_e req_type;
  eci_pkg::reg_sel_e  reg_sel;
  logic              acc, out_take;
  logic              g_ok, ch_ok, sel_grp, ch_on;
  logic [DW-1:0]     gm_sel, fire_set, fire_clr;
  eci_pkg::sub_t     sen_sel, sdis_sel;
  logic              gm_we, sen_we, sdis_we;

  assign req_type = eci_pkg::req_type_e'(req_i.req_type);
  assign reg_sel  = eci_pkg::reg_sel_e'(req_i.reg_sel);

  assign req_i.ready = !skid_vld_q;
  assign acc         = req_i.valid && !skid_vld_q;
  assign out_take    = out_vld_q && rsp_o.ready;

  assign g_ok    = {1'b0, req_i.group_index} < GrpLim;
  assign ch_ok   = {1'b0, req_i.event_channel} < ChLim;
  assign sel_grp = req_i.reg_sel >= eci_pkg::SelGrpMask;
  assign ch_on   = en_q[req_i.event_channel[ChIdxW-1:0]];

  always_comb begin
    gm_sel   = '0;
    sen_sel  = '0;
    sdis_sel = '0;
    fire_set = '0;
    fire_clr = '0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if ({1'b0, req_i.group_index} == (eci_pkg::GrpW+1)'(i)) begin
        gm_sel   = gmask_q[i];
        sen_sel  = suben_q[i];
        sdis_sel = subdis_q[i];
      end
      if (suben_q[i].on && suben_q[i].ch == req_i.event_channel) begin
        fire_set = fire_set | gmask_q[i];
      end
      if (subdis_q[i].on && subdis_q[i].ch == req_i.event_channel) begin
        fire_clr = fire_clr | gmask_q[i];
      end
    end
  end

  always_comb begin
    res       = '0;
    en_d      = en_q;
    gm_we     = 1'b0;
    sen_we    = 1'b0;
    sdis_we   = 1'b0;
    case (req_type)
      eci_pkg::ReqRead: begin
        if (sel_grp && !g_ok) begin
          res.bad_index = 1'b1;
        end else begin
          case (reg_sel)
            eci_pkg::SelChen,
            eci_pkg::SelChenSet: res.read_data = en_q;
            eci_pkg::SelGrpMask: res.read_data = gm_sel;
            eci_pkg::SelSubEn:   res.read_data = eci_pkg::sub_word(sen_sel);
            eci_pkg::SelSubDis:  res.read_data = eci_pkg::sub_word(sdis_sel);
            default:             res.read_data = '0;
          endcase
        end
      end
      eci_pkg::ReqWrite: begin
        if (sel_grp && !g_ok) begin
          res.bad_index = 1'b1;
        end else begin
          case (reg_sel)
            eci_pkg::SelChen:    en_d = req_i.write_data & ChMask;
            eci_pkg::SelChenSet: en_d = (en_q | req_i.write_data) & ChMask;
            eci_pkg::SelChenClr: en_d = en_q & ~req_i.write_data;
            eci_pkg::SelGrpMask: gm_we = !sen_sel.on && !sdis_sel.on;
            eci_pkg::SelGrpEn: begin
              if (req_i.write_data != '0) en_d = (en_q | gm_sel) & ChMask;
            end
            eci_pkg::SelGrpDis: begin
              if (req_i.write_data != '0) en_d = en_q & ~gm_sel;
            end
            eci_pkg::SelSubEn:   sen_we  = 1'b1;
            eci_pkg::SelSubDis:  sdis_we = 1'b1;
            default:             en_d = en_q;
          endcase
        end
      end
      eci_pkg::ReqEvent: begin
        if (!ch_ok) begin
          res.bad_index = 1'b1;
        end else if (ch_on) begin
          res.event_passed = 1'b1;
          en_d = ((en_q & ~fire_clr) | fire_set) & ChMask;
        end
      end
      default: res = '0;
    endcase
    res.channel_enables = en_d;
  end

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || out_take) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res;
        out_vld_d = acc;
      end
    end else if (acc) begin
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
      en_q       <= '0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        gmask_q[i]  <= '0;
        suben_q[i]  <= '0;
        subdis_q[i] <= '0;
      end
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
      if (acc) begin
        en_q <= en_d;
        for (int i = 0; i < NUM_GROUPS; i++) begin
          if ({1'b0, req_i.group_index} == (eci_pkg::GrpW+1)'(i)) begin
            if (gm_we)   gmask_q[i]  <= req_i.write_data & ChMask;
            if (sen_we)  suben_q[i]  <= '{on: req_i.write_data[eci_pkg::SubOnBit],
                                          ch: req_i.write_data[eci_pkg::ChW-1:0]};
            if (sdis_we) subdis_q[i] <= '{on: req_i.write_data[eci_pkg::SubOnBit],
                                          ch: req_i.write_data[eci_pkg::ChW-1:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (acc && out_vld_q && !out_take) begin
      skid_q <= res;
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.read_data       = out_q.read_data;
  assign rsp_o.event_passed    = out_q.event_passed;
  assign rsp_o.channel_enables = out_q.channel_enables;
  assign rsp_o.bad_index       = out_q.bad_index;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held with empty output register");

  a_mask_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_q & ~ChMask) == '0)
    else $error("enable mask holds a channel beyond range");

  a_accept_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !out_vld_q) |=> out_vld_q)
    else $error("accepted transaction did not reach output register");

  a_bad_not_passed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.bad_index) |-> (!out_q.event_passed && out_q.read_data == '0))
    else $error("ignored transaction reports data or a passed event");

  a_unchanged_mask_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(en_q))
    else $error("enable mask changed without an accepted transaction");

endmodule

[verif/eci_checker.sv]
// ----------------------------------------------------------------------------
// eci_checker
// Watches the request and response channels of the event channel
// interconnect. It keeps its own copy of the enable mask, group masks and
// group subscriptions, predicts one response per accepted request, and
// compares every accepted response field by field in order.
// ----------------------------------------------------------------------------
module eci_checker #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned NUM_GROUPS   = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  eci_req_if          req_i,
  eci_rsp_if          rsp_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW    = eci_pkg::DataW;
  localparam int unsigned SelW     = eci_pkg::SelW;
  localparam int unsigned GrpW     = eci_pkg::GrpW;
  localparam int unsigned ChW      = eci_pkg::ChW;
  localparam int unsigned ReqW     = eci_pkg::ReqW;
  localparam int unsigned SubOnBit = eci_pkg::SubOnBit;

  localparam logic [DataW-1:0] ChanMask = 32'hFFFF_FFFF >> (32 - NUM_CHANNELS);
  localparam logic [DataW-1:0] SubKeep  = (32'h1 << SubOnBit) | ((32'h1 << ChW) - 1);

  logic [DataW-1:0] chan_en;
  logic [DataW-1:0] grp_mask    [NUM_GROUPS];
  logic [DataW-1:0] grp_sub_en  [NUM_GROUPS];
  logic [DataW-1:0] grp_sub_dis [NUM_GROUPS];

  eci_pkg::rsp_t expected_rsp_q [$];

  function automatic bit sub_hit(logic [DataW-1:0] word, logic [ChW-1:0] ch);
    return word[SubOnBit] && (word[ChW-1:0] == ch);
  endfunction

  // Applies one transaction to the shadow state and returns its response.
  function automatic eci_pkg::rsp_t apply_transaction(logic [ReqW-1:0] rt,
                                                      logic [SelW-1:0] sel,
                                                      logic [GrpW-1:0] g,
                                                      logic [DataW-1:0] d,
                                                      logic [ChW-1:0] ch);
    eci_pkg::rsp_t    r;
    logic [DataW-1:0] set_m;
    logic [DataW-1:0] clr_m;
    r     = '0;
    set_m = '0;
    clr_m = '0;
    if (rt == eci_pkg::ReqRead || rt == eci_pkg::ReqWrite) begin
      if (sel >= eci_pkg::SelGrpMask && g >= NUM_GROUPS) begin
        r.bad_index = 1'b1;
      end else if (rt == eci_pkg::ReqRead) begin
        case (sel)
          eci_pkg::SelChen, eci_pkg::SelChenSet: r.read_data = chan_en;
          eci_pkg::SelGrpMask:                   r.read_data = grp_mask[g];
          eci_pkg::SelSubEn:                     r.read_data = grp_sub_en[g];
          eci_pkg::SelSubDis:                    r.read_data = grp_sub_dis[g];
          default:                               r.read_data = '0;
        endcase
      end else begin
        case (sel)
          eci_pkg::SelChen:    chan_en = d & ChanMask;
          eci_pkg::SelChenSet: chan_en = (chan_en | d) & ChanMask;
          eci_pkg::SelChenClr: chan_en = chan_en & ~d;
          eci_pkg::SelGrpMask: begin
            // mask is locked while either subscription is on
            if (!grp_sub_en[g][SubOnBit] && !grp_sub_dis[g][SubOnBit])
              grp_mask[g] = d & ChanMask;
          end
          eci_pkg::SelGrpEn:   if (d != '0) chan_en = (chan_en | grp_mask[g]) & ChanMask;
          eci_pkg::SelGrpDis:  if (d != '0) chan_en = chan_en & ~grp_mask[g];
          eci_pkg::SelSubEn:   grp_sub_en[g] = d & SubKeep;
          default:             grp_sub_dis[g] = d & SubKeep;
        endcase
      end
    end else if (rt == eci_pkg::ReqEvent) begin
      if (ch >= NUM_CHANNELS) begin
        r.bad_index = 1'b1;
      end else if (chan_en[ch]) begin
        r.event_passed = 1'b1;
        for (int i = 0; i < NUM_GROUPS; i++) begin
          if (sub_hit(grp_sub_en[i], ch))  set_m |= grp_mask[i];
          if (sub_hit(grp_sub_dis[i], ch)) clr_m |= grp_mask[i];
        end
        // enables win over disables
        chan_en = ((chan_en & ~clr_m) | set_m) & ChanMask;
      end
    end
    r.channel_enables = chan_en;
    return r;
  endfunction

  task automatic check_field(string name, logic [DataW-1:0] exp_v, logic [DataW-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, got_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    eci_pkg::rsp_t exp_rsp;
    if (!rst_ni) begin
      chan_en = '0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        grp_mask[i]    = '0;
        grp_sub_en[i]  = '0;
        grp_sub_dis[i] = '0;
      end
      expected_rsp_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response transaction with no request outstanding");
          fail_cnt_o++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          check_field("read_data", exp_rsp.read_data, rsp_i.read_data);
          check_field("event_passed", 32'(exp_rsp.event_passed), 32'(rsp_i.event_passed));
          check_field("channel_enables", exp_rsp.channel_enables, rsp_i.channel_enables);
          check_field("bad_index", 32'(exp_rsp.bad_index), 32'(rsp_i.bad_index));
        end
      end
      if (req_i.valid && req_i.ready)
        expected_rsp_q.push_back(apply_transaction(req_i.req_type, req_i.reg_sel,
                                                   req_i.group_index, req_i.write_data,
                                                   req_i.event_channel));
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for event_channel_interconnect_core. Drives a directed sequence
// of bus accesses and events, then random traffic in bursts against a
// stalling response side; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW    = eci_pkg::DataW;
  localparam int unsigned SelW     = eci_pkg::SelW;
  localparam int unsigned GrpW     = eci_pkg::GrpW;
  localparam int unsigned ChW      = eci_pkg::ChW;
  localparam int unsigned ReqW     = eci_pkg::ReqW;
  localparam int unsigned SubOnBit = eci_pkg::SubOnBit;

  localparam int unsigned NumChannels = 32;
  localparam int unsigned NumGroups   = 6;
  localparam int unsigned NumRandom   = 550;
  localparam int unsigned CycleLimit  = 200_000;

  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  localparam int RxAlways  = 0;
  localparam int RxRandom  = 1;
  localparam int RxPattern = 2;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [SelW-1:0]  reg_sel;
    logic [GrpW-1:0]  group_index;
    logic [DataW-1:0] write_data;
    logic [ChW-1:0]   event_channel;
  } eci_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned cycle_cnt = 0;

  int          rx_mode = RxAlways;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  eci_req_if req_if ();
  eci_rsp_if rsp_if ();

  event_channel_interconnect_core #(
    .NUM_CHANNELS(NumChannels),
    .NUM_GROUPS  (NumGroups)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  eci_checker #(
    .NUM_CHANNELS(NumChannels),
    .NUM_GROUPS  (NumGroups)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // response side: picks a new stall behavior whenever its countdown runs out
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(RxAlways, RxPattern);
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RxAlways: rsp_if.ready <= 1'b1;
      RxRandom: rsp_if.ready <= ($urandom_range(0, 3) != 0);
      default:  rsp_if.ready <= ((rx_tick % 11) < 4);
    endcase
  end

  function automatic eci_item_t mk(logic [ReqW-1:0] rt, logic [SelW-1:0] sel,
                                   logic [GrpW-1:0] g, logic [DataW-1:0] d,
                                   logic [ChW-1:0] ch);
    eci_item_t it;
    it.req_type      = rt;
    it.reg_sel       = sel;
    it.group_index   = g;
    it.write_data    = d;
    it.event_channel = ch;
    return it;
  endfunction

  function automatic logic [GrpW-1:0] rand_group();
    return ($urandom_range(0, 9) < 9) ? GrpW'($urandom_range(0, NumGroups - 1))
                                      : GrpW'($urandom_range(0, 7));
  endfunction

  function automatic eci_item_t rand_item();
    eci_item_t   it;
    int unsigned pick;
    it   = mk(ReqW'($urandom_range(0, 3)), SelW'($urandom_range(0, 7)),
              GrpW'($urandom_range(0, 7)), $urandom, ChW'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.req_type = eci_pkg::ReqEvent;
      if ($urandom_range(0, 99) < 85)
        it.event_channel = ChW'($urandom_range(0, NumChannels - 1));
    end else if (pick < 75) begin
      it.req_type    = eci_pkg::ReqWrite;
      it.group_index = rand_group();
      case (it.reg_sel)
        eci_pkg::SelSubEn, eci_pkg::SelSubDis: begin
          it.write_data[SubOnBit] = ($urandom_range(0, 9) < 6);
          if ($urandom_range(0, 3) != 0)
            it.write_data[ChW-1:0] = ChW'($urandom_range(0, NumChannels - 1));
        end
        eci_pkg::SelGrpEn, eci_pkg::SelGrpDis: begin
          if ($urandom_range(0, 4) == 0) it.write_data = '0;
        end
        default: if ($urandom_range(0, 1) == 0) it.write_data = $urandom & $urandom;
      endcase
    end else if (pick < 95) begin
      it.req_type    = eci_pkg::ReqRead;
      it.group_index = rand_group();
    end else begin
      it.req_type = ReqUnused;
    end
    return it;
  endfunction

  task automatic send_item(input eci_item_t it);
    req_if.valid         <= 1'b1;
    req_if.req_type      <= it.req_type;
    req_if.reg_sel       <= it.reg_sel;
    req_if.group_index   <= it.group_index;
    req_if.write_data    <= it.write_data;
    req_if.event_channel <= it.event_channel;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int unsigned n);
    req_if.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    eci_item_t   directed_q [$];
    int unsigned burst_left;
    req_if.valid         = 1'b0;
    req_if.req_type      = '0;
    req_if.reg_sel       = '0;
    req_if.group_index   = '0;
    req_if.write_data    = '0;
    req_if.event_channel = '0;
    rsp_if.ready         = 1'b0;
    burst_left           = 0;

    directed_q.push_back(mk(eci_pkg::ReqRead,  eci_pkg::SelChen,    3'd0, 32'h0, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelChen,    3'd0, 32'hFFFF_FFFF, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqRead,  eci_pkg::SelChenSet, 3'd0, 32'h0, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelChenClr, 3'd0, 32'h0000_FFFF, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelChenSet, 3'd0, 32'h0000_0001, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelGrpMask, 3'd0, 32'h0000_00F0, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelGrpMask, 3'd5, 32'hFFFF_00F0, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelGrpMask, 3'd6, 32'h1234_5678, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqRead,  eci_pkg::SelGrpMask, 3'd7, 32'h0, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelGrpEn,   3'd0, 32'h0, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelGrpEn,   3'd0, 32'h0000_0001, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelGrpDis,  3'd5, 32'h8000_0000, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqRead,  eci_pkg::SelChenClr, 3'd0, 32'h0, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqRead,  eci_pkg::SelGrpEn,   3'd0, 32'h0, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelSubEn,   3'd0, 32'hFFFF_FF05, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelSubDis,  3'd5, 32'h8000_0005, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelGrpMask, 3'd0, 32'h0000_000F, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelChenSet, 3'd0, 32'h0000_0020, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqEvent, eci_pkg::SelChen,    3'd0, 32'h0, 8'd5));
    directed_q.push_back(mk(eci_pkg::ReqRead,  eci_pkg::SelSubEn,   3'd0, 32'h0, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqRead,  eci_pkg::SelSubDis,  3'd5, 32'h0, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelSubEn,   3'd1, 32'h8000_0040, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqEvent, eci_pkg::SelChen,    3'd0, 32'h0, 8'd31));
    directed_q.push_back(mk(eci_pkg::ReqWrite, eci_pkg::SelChen,    3'd0, 32'h8000_0000, 8'd0));
    directed_q.push_back(mk(eci_pkg::ReqEvent, eci_pkg::SelChen,    3'd0, 32'h0, 8'd31));
    directed_q.push_back(mk(eci_pkg::ReqEvent, eci_pkg::SelChen,    3'd0, 32'h0, 8'd32));
    directed_q.push_back(mk(eci_pkg::ReqEvent, eci_pkg::SelChen,    3'd0, 32'h0, 8'd255));
    directed_q.push_back(mk(ReqUnused, eci_pkg::SelSubDis, 3'd7, 32'hFFFF_FFFF, 8'd255));

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_q[i]) send_item(directed_q[i]);
    drain();

    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      end
      burst_left--;
      send_item(rand_item());
    end

    drain();
    repeat (4) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
